### sv/page_bitmap_allocator_unit_defines.svh
// Assertion macros for the page bitmap allocator checker.
// No dependencies; included by the checker file only.
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PBA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pba assertion failed in %m");

// Next-cycle implication, disabled while reset is high.
`define PBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pba assertion failed in %m");

`endif

### sv/pba_pkg.sv
// Shared types and constants of the page bitmap allocator.
// No dependencies; imported by every module of the block.
package pba_pkg;

   // Page geometry
   localparam int unsigned PAGE_BYTES = 4096;
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned BIT_W      = 5;
   localparam logic [BIT_W-1:0] BIT_MAX = 5'd31;

   // Page index arithmetic width: holds first page + offset of any 32-bit region
   localparam int unsigned RANGE_W = 22;
   localparam int unsigned ADDR_W  = 27;

   // Request codes
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_REGION = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NOFREE = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   // Memory map entry kind that marks usable memory
   localparam logic [31:0] KIND_USABLE = 32'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_RANGE,
      ST_READ,
      ST_MODIFY,
      ST_RESP
   } state_type;

   typedef enum logic {
      ALU_ALLOC,
      ALU_CLEAR
   } alu_op_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic [5:0]           clr_count;
      logic                 found;
      logic [BIT_W-1:0]     bit_idx;
   } alu_res_type;

endpackage

### sv/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator: request sequencer, counters and
// result register. Depends on pba_pkg, pba_map_ram and pba_word_alu.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------
//  req_    | in  | req_tvalid/tready    | tuser: req_type; tdata: region fields
//  rsp_    | out | rsp_tvalid/tready    | tuser: status; tdata: addr/counts
//  csr_    | in  | csr_we (no wait)     | csr_wdata: kernel end address
//
// Sequence: allocate reads bitmap words upward from the lowest word that may hold a free
// page, free reads and clears one word, region clears each word the freed span touches;
// a zero free count, out-of-range free, unusable region or empty span skips the bitmap.
// Reset: a clearing pass over every bitmap word marks every page used; req_tready low.
// Stalls: one transaction in flight, req_tready returns the cycle after the result loads;
// a finished result waits in RESP while the output register holds an untaken one.
module page_bitmap_allocator_unit
   import pba_pkg::*;
#(
   parameter int unsigned PAGE_COUNT = 32768
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // region_kind, region_base_hi, region_base,
                                    // region_length, free_addr (32 bits each)
   input  logic [1:0]   req_tuser,  // req_type
   // Result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,  // page_addr[26:0], free_pages[42:27],
                                    // region_total[74:43], zero pad[79:75]
   output logic [1:0]   rsp_tuser,  // status
   // Configuration
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata   // kernel end address
);

   localparam int unsigned MAP_WORDS = (PAGE_COUNT + 31) / 32;
   localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned CW        = $clog2(PAGE_COUNT + 1);
   localparam logic [WW-1:0]      LAST_WORD = WW'(MAP_WORDS - 1);
   localparam logic [RANGE_W-1:0] PC_R      = RANGE_W'(PAGE_COUNT);
   localparam logic [32:0]        PB_M1     = 33'(PAGE_BYTES - 1);

   state_type            state_ff, state_in;
   logic [31:0]          kend_ff;
   logic [1:0]           op_ff, op_in;
   logic [31:0]          kind_ff, kind_in;
   logic [31:0]          bhigh_ff, bhigh_in;
   logic [31:0]          base_ff, base_in;
   logic [31:0]          len_ff, len_in;
   logic [31:0]          faddr_ff, faddr_in;
   logic [RANGE_W-1:0]   first_ff, first_in;
   logic [RANGE_W-1:0]   steps_ff, steps_in;
   logic [RANGE_W-1:0]   kmin_ff, kmin_in;
   logic [RANGE_W-1:0]   s_ff, s_in;
   logic [RANGE_W-1:0]   last_ff, last_in;
   logic [WW-1:0]        w_ff, w_in;
   logic [WW-1:0]        hint_ff, hint_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [31:0]          total_ff, total_in;
   logic [1:0]           status_ff, status_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [74:0]          rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [WW-1:0]        ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   alu_op_type           alu_op;
   logic [BIT_W-1:0]     alu_lo, alu_hi;
   alu_res_type          alu_res;

   // Combinational helpers for range setup
   logic [RANGE_W-1:0]   page_sel;
   logic [31:0]          kdiff;
   logic [RANGE_W-1:0]   room;
   logic [RANGE_W-1:0]   kmax;
   logic [RANGE_W-1:0]   span_start;
   logic [WW-1:0]        start_word;
   logic [WW+BIT_W+PAGE_SHIFT-1:0] full_addr;

   pba_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (WW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pba_word_alu u_alu (
      .op     (alu_op),
      .word   (ram_rdata),
      .lo_bit (alu_lo),
      .hi_bit (alu_hi),
      .res    (alu_res)
   );

   // Word unit controls: span edges apply only on the first and last word
   assign alu_op = (op_ff == REQ_ALLOC) ? ALU_ALLOC : ALU_CLEAR;
   assign alu_lo = (w_ff == s_ff[WW+4:5])    ? s_ff[4:0]    : '0;
   assign alu_hi = (w_ff == last_ff[WW+4:5]) ? last_ff[4:0] : BIT_MAX;

   assign page_sel   = RANGE_W'(faddr_ff >> PAGE_SHIFT);
   assign kdiff      = kend_ff - base_ff;
   assign room       = PC_R - first_ff;
   assign kmax       = (first_ff >= PC_R) ? '0 : ((room < steps_ff) ? room : steps_ff);
   assign span_start = first_ff + kmin_ff;
   assign start_word = (state_ff == ST_SETUP) ? page_sel[WW+4:5] : span_start[WW+4:5];
   assign full_addr  = {w_ff, alu_res.bit_idx, {PAGE_SHIFT{1'b0}}};

   // Control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         kend_ff      <= '0;
         w_ff         <= '0;
         hint_ff      <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            kend_ff <= csr_wdata;
         end
         w_ff         <= w_in;
         hint_ff      <= hint_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      kind_ff       <= kind_in;
      bhigh_ff      <= bhigh_in;
      base_ff       <= base_in;
      len_ff        <= len_in;
      faddr_ff      <= faddr_in;
      first_ff      <= first_in;
      steps_ff      <= steps_in;
      kmin_ff       <= kmin_in;
      s_ff          <= s_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      kind_in       = kind_ff;
      bhigh_in      = bhigh_ff;
      base_in       = base_ff;
      len_in        = len_ff;
      faddr_in      = faddr_ff;
      first_in      = first_ff;
      steps_in      = steps_ff;
      kmin_in       = kmin_ff;
      s_in          = s_ff;
      last_in       = last_ff;
      w_in          = w_ff;
      hint_in       = hint_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = w_ff;
      ram_wdata     = alu_res.new_word;
      ram_re        = 1'b0;
      ram_raddr     = w_ff;
      req_tready    = 1'b0;

      // Drop the output transaction once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Mark every page used, one word a cycle
            ram_we    = 1'b1;
            ram_wdata = 32'hFFFF_FFFF;
            if (w_ff == LAST_WORD) begin
               w_in     = '0;
               state_in = ST_IDLE;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = req_tuser;
               kind_in   = req_tdata[31:0];
               bhigh_in  = req_tdata[63:32];
               base_in   = req_tdata[95:64];
               len_in    = req_tdata[127:96];
               faddr_in  = req_tdata[159:128];
               status_in = STATUS_OK;
               addr_in   = '0;
               state_in  = ST_SETUP;
            end
         end

         ST_SETUP: begin
            state_in = ST_RESP;
            case (op_ff)
               REQ_ALLOC: begin
                  if (cnt_ff == '0) begin
                     status_in = STATUS_NOFREE;
                  end else begin
                     w_in     = hint_ff;
                     state_in = ST_READ;
                  end
               end
               REQ_FREE: begin
                  if (page_sel >= PC_R) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     s_in     = page_sel;
                     last_in  = page_sel;
                     w_in     = start_word;
                     if (start_word < hint_ff) begin
                        hint_in = start_word;
                     end
                     state_in = ST_READ;
                  end
               end
               REQ_REGION: begin
                  if (kind_ff == KIND_USABLE && bhigh_ff == '0) begin
                     first_in = RANGE_W'(base_ff >> PAGE_SHIFT);
                     steps_in = RANGE_W'((33'(len_ff) + PB_M1) >> PAGE_SHIFT);
                     kmin_in  = (kend_ff > base_ff)
                              ? RANGE_W'((33'(kdiff) + PB_M1) >> PAGE_SHIFT) : '0;
                     total_in = total_ff + (len_ff >> PAGE_SHIFT);
                     state_in = ST_RANGE;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_RANGE: begin
            // Clip the walk to the map and to pages above the kernel
            if (kmin_ff < kmax) begin
               s_in    = span_start;
               last_in = first_ff + kmax - 1'b1;
               w_in    = start_word;
               if (start_word < hint_ff) begin
                  hint_in = start_word;
               end
               state_in = ST_READ;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_MODIFY;
         end

         ST_MODIFY: begin
            if (op_ff == REQ_ALLOC) begin
               if (alu_res.found) begin
                  ram_we   = 1'b1;
                  cnt_in   = cnt_ff - 1'b1;
                  addr_in  = ADDR_W'(full_addr);
                  hint_in  = w_ff;
                  state_in = ST_RESP;
               end else if (w_ff == LAST_WORD) begin
                  status_in = STATUS_NOFREE;
                  state_in  = ST_RESP;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               ram_we = 1'b1;
               cnt_in = cnt_ff + CW'(alu_res.clr_count);
               if (w_ff == last_ff[WW+4:5]) begin
                  state_in = ST_RESP;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end

         ST_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {total_ff, 16'(32'(cnt_ff)), addr_ff};
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

### sv/pba_map_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
// Depends on pba_pkg for the word width.
module pba_map_ram
   import pba_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pba_word_alu.sv
// Shared bitmap word unit: lowest-zero search and set for allocation,
// masked clear with popcount of newly freed pages for free and region walks.
// Depends on pba_pkg.
module pba_word_alu
   import pba_pkg::*;
(
   input  alu_op_type           op,
   input  logic [WORD_BITS-1:0] word,
   input  logic [BIT_W-1:0]     lo_bit,
   input  logic [BIT_W-1:0]     hi_bit,
   output alu_res_type          res
);

   logic [WORD_BITS-1:0] low_zero;
   logic [WORD_BITS-1:0] clr_mask;
   logic [WORD_BITS-1:0] freed;
   logic [BIT_W-1:0]     idx;

   // Isolate the lowest clear bit
   assign low_zero = ~word & (word + 32'd1);

   // Span of bits lo_bit..hi_bit
   assign clr_mask = (32'hFFFF_FFFF << lo_bit) & (32'hFFFF_FFFF >> (BIT_MAX - hi_bit));
   assign freed    = word & clr_mask;

   // Encode the one-hot lowest zero
   always_comb begin
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_zero[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
   end

   always_comb begin
      res.bit_idx   = idx;
      res.found     = (word != 32'hFFFF_FFFF);
      res.clr_count = 6'($countones(freed));
      case (op)
         ALU_ALLOC: res.new_word = word | low_zero;
         ALU_CLEAR: res.new_word = word & ~clr_mask;
         default:   res.new_word = word;
      endcase
   end

endmodule

### sv/pba_checker.sv
// Port-level checker for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg and page_bitmap_allocator_unit_defines.svh.
`include "page_bitmap_allocator_unit_defines.svh"

module pba_checker
   import pba_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // Stalled result transaction holds
   `PBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // One request in flight: ready drops after each accepted transaction
   `PBA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // Allocation failure only when no page is free
   `PBA_ASSERT_NOW(a_nofree_empty, clock, reset,
      rsp_tvalid && rsp_tuser == STATUS_NOFREE, rsp_tdata[42:27] == 16'd0)

   // Only a successful transaction may carry a page address
   `PBA_ASSERT_NOW(a_addr_on_ok, clock, reset,
      rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata[26:0] == 27'd0)

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);

### tb/sv/tb_page_bitmap_allocator_unit.sv
// Self-checking testbench for page_bitmap_allocator_unit: request transactions are
// predicted against a bitmap model of the page map and every reply field is compared.
// Depends on pba_pkg and the allocator RTL; no other files.
module tb_page_bitmap_allocator_unit;
   import pba_pkg::*;

   localparam int unsigned MAP_PAGES    = 32768;
   localparam int unsigned MAP_WORDS    = MAP_PAGES / WORD_BITS;
   localparam int unsigned WINDOW_PAGES = 1024;
   localparam int unsigned STALL_LIMIT  = 20000;
   localparam logic [63:0] PB64         = PAGE_BYTES;
   localparam logic [1:0]  REQ_UNUSED   = 2'd3;

   typedef struct {
      logic [1:0]  req_type;
      logic [31:0] region_kind;
      logic [31:0] region_base_hi;
      logic [31:0] region_base;
      logic [31:0] region_length;
      logic [31:0] free_addr;
   } page_req_type;

   typedef struct {
      logic [1:0]        status;
      logic [ADDR_W-1:0] page_addr;
      logic [15:0]       free_pages;
      logic [31:0]       region_total;
   } page_reply_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we     = 1'b0;
   logic [31:0]  csr_wdata  = '0;

   // Model state of the page map
   logic [WORD_BITS-1:0] used_bits [MAP_WORDS];
   int unsigned          free_page_count;
   logic [31:0]          region_page_sum;
   logic [31:0]          kern_limit;
   page_reply_type       alloc_replies_due [$];

   int unsigned req_gap_max     = 19;
   int unsigned rsp_gap_max     = 19;
   int unsigned rsp_hold_cycles = 0;
   int unsigned mismatch_count  = 0;
   int unsigned stall_cycles    = 0;

   page_bitmap_allocator_unit #(
      .PAGE_COUNT(MAP_PAGES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mark one page free, counting it only when it was used
   function automatic void release_page(input int unsigned page);
      if (used_bits[page / WORD_BITS][page % WORD_BITS]) begin
         used_bits[page / WORD_BITS][page % WORD_BITS] = 1'b0;
         free_page_count++;
      end
   endfunction

   // Walk a usable region: free pages in range and at or above the kernel end
   function automatic void add_region(input logic [31:0] base, input logic [31:0] len);
      logic [63:0] first_page;
      logic [63:0] span;
      logic [63:0] skip;
      logic [63:0] limit;
      logic [63:0] k;
      first_page = {32'd0, base} / PB64;
      span       = ({32'd0, len} + PB64 - 64'd1) / PB64;
      skip       = 64'd0;
      if (kern_limit > base) begin
         skip = ({32'd0, kern_limit} - {32'd0, base} + PB64 - 64'd1) / PB64;
      end
      if (first_page >= MAP_PAGES) begin
         limit = 64'd0;
      end else begin
         limit = MAP_PAGES - first_page;
         if (span < limit) limit = span;
      end
      for (k = skip; k < limit; k++) release_page(32'(first_page + k));
      region_page_sum += len >> PAGE_SHIFT;
   endfunction

   // Apply one request to the page map and return the reply it causes
   function automatic page_reply_type page_map_step(input page_req_type r);
      page_reply_type rep;
      int unsigned w;
      int unsigned b;
      int unsigned page;
      logic [31:0] byte_addr;
      bit          found;
      rep.status    = STATUS_OK;
      rep.page_addr = '0;
      case (r.req_type)
         REQ_ALLOC: begin
            found = 1'b0;
            for (w = 0; w < MAP_WORDS && !found; w++) begin
               if (used_bits[w] != '1) begin
                  for (b = 0; b < WORD_BITS && !found; b++) begin
                     if (!used_bits[w][b]) begin
                        used_bits[w][b] = 1'b1;
                        free_page_count--;
                        page          = w * WORD_BITS + b;
                        byte_addr     = page << PAGE_SHIFT;
                        rep.page_addr = byte_addr[ADDR_W-1:0];
                        found         = 1'b1;
                     end
                  end
               end
            end
            if (!found) rep.status = STATUS_NOFREE;
         end
         REQ_FREE: begin
            page = r.free_addr >> PAGE_SHIFT;
            if (page >= MAP_PAGES) rep.status = STATUS_RANGE;
            else release_page(page);
         end
         REQ_REGION: begin
            if (r.region_kind == KIND_USABLE && r.region_base_hi == '0) begin
               add_region(r.region_base, r.region_length);
            end
         end
         default: ;
      endcase
      rep.free_pages   = free_page_count[15:0];
      rep.region_total = region_page_sum;
      return rep;
   endfunction

   function automatic page_req_type random_fields();
      page_req_type r;
      r.req_type       = 2'($urandom_range(3, 0));
      r.region_kind    = $urandom;
      r.region_base_hi = $urandom;
      r.region_base    = $urandom;
      r.region_length  = $urandom;
      r.free_addr      = $urandom;
      return r;
   endfunction

   // Mostly well-formed traffic inside a low window of pages, plus noise
   function automatic page_req_type random_mixed_req(input int unsigned alloc_pct);
      page_req_type r;
      int unsigned  roll;
      r    = random_fields();
      roll = $urandom_range(99, 0);
      if (roll < alloc_pct) begin
         r.req_type = REQ_ALLOC;
      end else if (roll < 65) begin
         r.req_type  = REQ_FREE;
         r.free_addr = ($urandom_range(WINDOW_PAGES - 1, 0) << PAGE_SHIFT) |
                       $urandom_range(PAGE_BYTES - 1, 0);
      end else if (roll < 83) begin
         r.req_type       = REQ_REGION;
         r.region_kind    = KIND_USABLE;
         r.region_base_hi = '0;
         r.region_base    = $urandom_range(WINDOW_PAGES * PAGE_BYTES - 1, 0);
         r.region_length  = $urandom_range(64 * PAGE_BYTES, 0);
      end else if (roll < 88) begin
         r.req_type = REQ_FREE;
      end else if (roll < 94) begin
         r.req_type = REQ_REGION;
         if ($urandom_range(1, 0)) r.region_kind = KIND_USABLE;
         if ($urandom_range(1, 0)) r.region_base_hi = '0;
      end else if (roll < 97) begin
         r.req_type       = REQ_REGION;
         r.region_kind    = KIND_USABLE;
         r.region_base_hi = '0;
      end else begin
         r.req_type = REQ_UNUSED;
      end
      return r;
   endfunction

   // Offer one request after a random gap; predict its reply on acceptance
   task automatic send_req(input page_req_type r);
      int unsigned gap;
      gap = $urandom_range(req_gap_max, 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.req_type;
      req_tdata  <= {r.free_addr, r.region_length, r.region_base,
                     r.region_base_hi, r.region_kind};
      do @(posedge clock); while (!req_tready);
      alloc_replies_due.push_back(page_map_step(r));
   endtask

   task automatic send_alloc();
      page_req_type r;
      r          = random_fields();
      r.req_type = REQ_ALLOC;
      send_req(r);
   endtask

   task automatic send_free(input logic [31:0] addr);
      page_req_type r;
      r           = random_fields();
      r.req_type  = REQ_FREE;
      r.free_addr = addr;
      send_req(r);
   endtask

   task automatic send_region(input logic [31:0] kind, input logic [31:0] base_hi,
                              input logic [31:0] base, input logic [31:0] len);
      page_req_type r;
      r                = random_fields();
      r.req_type       = REQ_REGION;
      r.region_kind    = kind;
      r.region_base_hi = base_hi;
      r.region_base    = base;
      r.region_length  = len;
      send_req(r);
   endtask

   // Drop valid and wait until every predicted reply has been taken
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      while (alloc_replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_kern_limit(input logic [31:0] value);
      wait_block_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      kern_limit  = value;
   endtask

   // Empty map after reset: every request kind and the range edges
   task automatic test_empty_map();
      page_req_type r;
      send_alloc();
      send_free(32'hFFFF_FFFF);
      send_free(32'h0800_0000);
      r          = random_fields();
      r.req_type = REQ_UNUSED;
      send_req(r);
      send_region(32'd0, 32'd0, 32'h0000_0000, 32'h0001_0000);
      send_region(KIND_USABLE, 32'd1, 32'h0000_0000, 32'h0001_0000);
      send_region(KIND_USABLE, 32'd0, 32'h0000_3000, 32'h0000_2000);
      send_alloc();
   endtask

   // Unaligned kernel end, frees below it, duplicate frees, odd lengths
   task automatic test_kern_limit();
      write_kern_limit(32'h0000_5800);
      send_region(KIND_USABLE, 32'd0, 32'h0000_1000, 32'h0000_8000);
      send_alloc();
      send_free(32'h0000_0000);
      send_alloc();
      send_free(32'h0000_7123);
      send_region(KIND_USABLE, 32'd0, 32'h0000_9000, 32'h0000_0000);
      send_region(KIND_USABLE, 32'd0, 32'h0080_0000, 32'h0000_1FFF);
   endtask

   // Whole-map regions, last page, high bases and the largest kernel end
   task automatic test_extremes();
      write_kern_limit(32'h0000_0000);
      send_region(KIND_USABLE, 32'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_free(32'h07FF_FFFF);
      repeat (3) send_alloc();
      send_region(KIND_USABLE, 32'd0, 32'hFFFF_F000, 32'hFFFF_FFFF);
      send_region(KIND_USABLE, 32'd0, 32'h07FF_F000, 32'h0000_1000);
      write_kern_limit(32'hFFFF_FFFF);
      send_region(KIND_USABLE, 32'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_free(32'h0000_0000);
   endtask

   task automatic test_random_traffic();
      write_kern_limit($urandom_range(WINDOW_PAGES * PAGE_BYTES - 1, 0));
      repeat (500) send_req(random_mixed_req(35));
      write_kern_limit(32'h0000_0000);
      repeat (300) send_req(random_mixed_req(35));
      write_kern_limit($urandom);
      repeat (300) send_req(random_mixed_req(25));
      write_kern_limit(32'h0020_0000);
      repeat (250) send_req(random_mixed_req(40));
      write_kern_limit(32'h0000_0FFF);
      repeat (250) send_req(random_mixed_req(35));
   endtask

   // Hold the reply side off while requests keep coming, so the input stalls
   task automatic test_output_stall();
      rsp_hold_cycles = 400;
      repeat (20) send_req(random_mixed_req(35));
   endtask

   // Large out-of-range regions that push the region page total up quickly
   task automatic test_total_growth();
      wait_block_idle();
      repeat (150) begin
         send_region(KIND_USABLE, 32'd0, $urandom_range(32'hFFFF_FFFF, 32'h0800_0000),
                     32'hFFFF_F000 | $urandom_range(PAGE_BYTES - 1, 0));
      end
   endtask

   // Take replies with random stalls and compare them in order
   initial begin : reply_checker
      page_reply_type want;
      page_reply_type got;
      int unsigned    gap;
      forever begin
         if (rsp_hold_cycles != 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(rsp_gap_max, 0);
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.status       = rsp_tuser;
         got.page_addr    = rsp_tdata[ADDR_W-1:0];
         got.free_pages   = rsp_tdata[ADDR_W+15:ADDR_W];
         got.region_total = rsp_tdata[ADDR_W+47:ADDR_W+16];
         if (alloc_replies_due.size() == 0) begin
            $error("reply transaction with none pending: status %0d page_addr %0h",
                   got.status, got.page_addr);
            mismatch_count++;
         end else begin
            want = alloc_replies_due.pop_front();
            if (got.status != want.status) begin
               $error("status expected %0d got %0d", want.status, got.status);
               mismatch_count++;
            end
            if (got.page_addr != want.page_addr) begin
               $error("page_addr expected %0h got %0h", want.page_addr, got.page_addr);
               mismatch_count++;
            end
            if (got.free_pages != want.free_pages) begin
               $error("free_pages expected %0d got %0d", want.free_pages, got.free_pages);
               mismatch_count++;
            end
            if (got.region_total != want.region_total) begin
               $error("region_total expected %0h got %0h",
                      want.region_total, got.region_total);
               mismatch_count++;
            end
         end
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("tb_page_bitmap_allocator_unit: FAIL");
         $finish;
      end
   end

   initial begin
      foreach (used_bits[i]) used_bits[i] = '1;
      free_page_count = 0;
      region_page_sum = '0;
      kern_limit      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_map();
      test_kern_limit();
      test_extremes();
      test_random_traffic();
      test_output_stall();
      test_total_growth();
      wait_block_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_page_bitmap_allocator_unit: PASS");
      end else begin
         $display("tb_page_bitmap_allocator_unit: FAIL");
      end
      $finish;
   end

endmodule
